/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the RTL top level of the bit sequencer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked on the clock edge that follows a reset cycle.
`define ASSERT_AFTER_RESET(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (prop)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_AFTER_RESET(label, clk, rstn, prop, msg)

`endif

`endif

/* hdl/i2cbs_pkg.sv */
// ---------------------------------------------------------------------------
// I2C bit sequencer package
// Command codes, request and result payloads, and the sequencer state record.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

    // Command codes carried in the op field and held as the running command.
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_ACK   = 3'd5
    } cmd_t;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam logic [7:0]  BYTE_MSB          = 8'h80;
    localparam logic [7:0]  READ_BIT          = 8'h01;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    // One input request: a single tick of the bus timebase.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       read_dir;
        logic       ack_enable;
        logic       sda_in;
    } i2cbs_in_t;

    // One result: line levels and read status for that tick.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
    } i2cbs_out_t;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  phase;
        logic [3:0]  bits;
        logic [7:0]  shift;
        logic [15:0] ticks;
        logic        scl;
        logic        sda;
    } i2cbs_state_t;

endpackage

`default_nettype wire

/* hdl/i2cbs_step.sv */
// ---------------------------------------------------------------------------
// I2C bit sequencer tick logic
// Combinational next state and result for one tick of the bus timebase.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cbs_step (
    input  wire i2cbs_pkg::i2cbs_state_t state_i,
    input  wire i2cbs_pkg::i2cbs_in_t    item_i,
    input  wire logic [15:0]             half_period_i,
    output i2cbs_pkg::i2cbs_state_t      state_o,
    output i2cbs_pkg::i2cbs_out_t        result_o
);

    // Drive the line levels that belong to the current phase.
    function automatic i2cbs_pkg::i2cbs_state_t set_levels(i2cbs_pkg::i2cbs_state_t s);
        i2cbs_pkg::i2cbs_state_t r;
        r = s;
        case (s.cmd)
            i2cbs_pkg::CMD_START: begin
                if (s.phase == 3'd0)      r.sda = 1'b1;
                else if (s.phase == 3'd1) r.scl = 1'b1;
                else if (s.phase == 3'd2) r.sda = 1'b0;
                else                      r.scl = 1'b0;
            end
            i2cbs_pkg::CMD_WRITE: begin
                if (s.phase == 3'd0) begin
                    r.scl = 1'b0;
                    r.sda = (s.shift & i2cbs_pkg::BYTE_MSB) != 8'd0;
                end else if (s.phase == 3'd1) begin
                    r.scl = 1'b1;
                end else if (s.phase == 3'd2) begin
                    r.scl = 1'b0;
                end else if (s.phase == 3'd3) begin
                    r.scl = 1'b0;
                    r.sda = 1'b1;
                end else begin
                    r.scl = 1'b1;
                end
            end
            i2cbs_pkg::CMD_READ: begin
                if (s.phase == 3'd0) begin
                    r.scl = 1'b1;
                    r.sda = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            i2cbs_pkg::CMD_STOP: begin
                if (s.phase == 3'd0)      r.scl = 1'b0;
                else if (s.phase == 3'd1) r.sda = 1'b0;
                else if (s.phase == 3'd2) r.scl = 1'b1;
                else                      r.sda = 1'b1;
            end
            i2cbs_pkg::CMD_ACK: begin
                r.scl = 1'b1;
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

    i2cbs_pkg::i2cbs_state_t s;
    logic [15:0] hp;
    logic [16:0] tick_sum;
    logic        read_done;
    logic        out_scl;
    logic        out_sda;

    always_comb begin
        s         = state_i;
        read_done = 1'b0;
        hp        = (half_period_i == 16'd0) ? 16'd1 : half_period_i;

        // An idle sequencer takes a new command; unknown codes are plain ticks.
        if (s.cmd == i2cbs_pkg::CMD_IDLE &&
            item_i.op inside {[i2cbs_pkg::CMD_START : i2cbs_pkg::CMD_ACK]}) begin
            s.cmd   = i2cbs_pkg::cmd_t'(item_i.op);
            s.phase = 3'd0;
            s.bits  = 4'd0;
            s.ticks = 16'd0;
            case (s.cmd)
                i2cbs_pkg::CMD_START:
                    s.shift = item_i.read_dir ? (item_i.data | i2cbs_pkg::READ_BIT)
                                              : item_i.data;
                i2cbs_pkg::CMD_WRITE: s.shift = item_i.data;
                i2cbs_pkg::CMD_READ:  s.shift = 8'd0;
                i2cbs_pkg::CMD_ACK:   s.sda   = !item_i.ack_enable;
                default:              s.shift = s.shift;
            endcase
            s = set_levels(s);
        end

        out_scl  = s.scl;
        out_sda  = s.sda;
        tick_sum = {1'b0, s.ticks} + 17'd1;

        // Count the tick and close the phase when its length is reached.
        if (s.cmd != i2cbs_pkg::CMD_IDLE) begin
            if (tick_sum >= {1'b0, hp}) begin
                s.ticks = 16'd0;
                case (s.cmd)
                    i2cbs_pkg::CMD_START: begin
                        if (s.phase < 3'd3) begin
                            s.phase = s.phase + 3'd1;
                        end else begin
                            s.cmd   = i2cbs_pkg::CMD_WRITE;
                            s.phase = 3'd0;
                            s.bits  = 4'd0;
                        end
                    end
                    i2cbs_pkg::CMD_WRITE: begin
                        if (s.phase == 3'd2) begin
                            s.shift = {s.shift[6:0], 1'b0};
                            s.bits  = s.bits + 4'd1;
                            s.phase = (s.bits < i2cbs_pkg::BITS_PER_BYTE) ? 3'd0 : 3'd3;
                        end else if (s.phase < 3'd4) begin
                            s.phase = s.phase + 3'd1;
                        end else begin
                            s.scl   = 1'b0;
                            s.cmd   = i2cbs_pkg::CMD_IDLE;
                            s.phase = 3'd0;
                            s.bits  = 4'd0;
                        end
                    end
                    i2cbs_pkg::CMD_READ: begin
                        if (s.phase == 3'd0) begin
                            s.shift = {s.shift[6:0], item_i.sda_in};
                            s.phase = 3'd1;
                        end else begin
                            s.bits = s.bits + 4'd1;
                            if (s.bits < i2cbs_pkg::BITS_PER_BYTE) begin
                                s.phase = 3'd0;
                            end else begin
                                s.scl     = 1'b0;
                                s.cmd     = i2cbs_pkg::CMD_IDLE;
                                s.phase   = 3'd0;
                                s.bits    = 4'd0;
                                read_done = 1'b1;
                            end
                        end
                    end
                    i2cbs_pkg::CMD_STOP: begin
                        if (s.phase < 3'd3) begin
                            s.phase = s.phase + 3'd1;
                        end else begin
                            s.cmd   = i2cbs_pkg::CMD_IDLE;
                            s.phase = 3'd0;
                            s.bits  = 4'd0;
                        end
                    end
                    default: begin
                        // Send-ack ends after one phase with SCL pulled low.
                        s.scl   = 1'b0;
                        s.cmd   = i2cbs_pkg::CMD_IDLE;
                        s.phase = 3'd0;
                        s.bits  = 4'd0;
                    end
                endcase
                if (s.cmd != i2cbs_pkg::CMD_IDLE) begin
                    s = set_levels(s);
                end
            end else begin
                s.ticks = tick_sum[15:0];
            end
        end

        state_o             = s;
        result_o.scl        = out_scl;
        result_o.sda        = out_sda;
        result_o.busy_res   = (s.cmd != i2cbs_pkg::CMD_IDLE);
        result_o.read_valid = read_done;
        result_o.read_data  = read_done ? s.shift : 8'd0;
    end

endmodule

`default_nettype wire

/* hdl/i2c_master_bit_sequencer_top.sv */
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Turns one request per bus timebase tick into SCL and SDA levels for that tick.
// ---------------------------------------------------------------------------
//  Channel   Ports                         Payload
//  request   s_valid, s_ready, s_data      op, data, read_dir, ack_enable, sda_in
//  result    m_valid, m_ready, m_data      scl, sda, busy_res, read_valid, read_data
//  config    cfg_we, cfg_wdata             half_period
//
// One request per cycle while results are taken; requests pass the request register,
// then the result register. The rate is set by the single state update in the tick
// logic between the request register and the result register. Reset clears
// both registers and the sequencer state and sets half_period to 250. A stalled result
// holds the request register, which then holds s_ready low until the result is taken.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_bit_sequencer_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire i2cbs_pkg::i2cbs_in_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output i2cbs_pkg::i2cbs_out_t      m_data,
    input  wire logic                  cfg_we,
    input  wire logic [15:0]           cfg_wdata
);

    logic                    in_valid_reg;
    logic                    in_valid_next;
    i2cbs_pkg::i2cbs_in_t    in_data_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    i2cbs_pkg::i2cbs_out_t   out_data_reg;
    i2cbs_pkg::i2cbs_state_t state_reg;
    i2cbs_pkg::i2cbs_state_t state_next;
    i2cbs_pkg::i2cbs_out_t   result;
    logic [15:0]             half_period_reg;
    logic                    proc_fire;
    logic                    s_fire;

    // Handshake control for the request and result registers.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);
        out_valid_next = proc_fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // Tick logic for one request.
    i2cbs_step u_step (
        .state_i       (state_reg),
        .item_i        (in_data_reg),
        .half_period_i (half_period_reg),
        .state_o       (state_next),
        .result_o      (result)
    );

    // Control state, sequencer state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            half_period_reg <= i2cbs_pkg::HALF_PERIOD_RESET;
            state_reg.cmd   <= i2cbs_pkg::CMD_IDLE;
            state_reg.phase <= 3'd0;
            state_reg.bits  <= 4'd0;
            state_reg.shift <= 8'd0;
            state_reg.ticks <= 16'd0;
            state_reg.scl   <= 1'b0;
            state_reg.sda   <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                half_period_reg <= cfg_wdata;
            end
            if (proc_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
        if (proc_fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A completed read always ends the command.
    `ASSERT_PROP(a_read_ends_cmd, aclk, aresetn, (m_valid && m_data.read_valid) |-> !m_data.busy_res, "read completed while busy")
    // Read data is zero unless a read completed.
    `ASSERT_PROP(a_read_data_zero, aclk, aresetn, (m_valid && !m_data.read_valid) |-> (m_data.read_data == 8'd0), "stray read data")
    // An idle sequencer has its phase and bit counters cleared.
    `ASSERT_PROP(a_idle_clear, aclk, aresetn, (state_reg.cmd == i2cbs_pkg::CMD_IDLE) |-> (state_reg.phase == 3'd0 && state_reg.bits == 4'd0), "idle with counters set")
    // Reset empties both registers.
    `ASSERT_AFTER_RESET(a_reset_empty, aclk, aresetn, !in_valid_reg && !out_valid_reg, "registers not empty after reset")

endmodule

`default_nettype wire

/* sim/i2c_master_bit_sequencer_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C bit sequencer checker
// Watches the request, result and configuration ports of the sequencer. Each
// accepted request is run through a cycle-level model of the line sequencer, and
// each accepted result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  i2cbs_pkg::i2cbs_in_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  i2cbs_pkg::i2cbs_out_t m_data,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    output int unsigned           fail_count,
    output int unsigned           pending_count
);

    // Model copy of the sequencer state and of the half period register.
    i2cbs_pkg::cmd_t run_cmd;
    logic [2:0]      phase;
    logic [3:0]      bit_cnt;
    logic [7:0]      shreg;
    logic [15:0]     tick_cnt;
    logic            scl_q;
    logic            sda_q;
    logic [15:0]     half_per;

    // Line levels predicted for requests still in flight, oldest first.
    i2cbs_pkg::i2cbs_out_t expected_lines[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Line levels that the current phase of the running command calls for.
    function void apply_levels();
        case (run_cmd)
            i2cbs_pkg::CMD_START: begin
                if (phase == 3'd0) sda_q = 1'b1;
                else if (phase == 3'd1) scl_q = 1'b1;
                else if (phase == 3'd2) sda_q = 1'b0;
                else scl_q = 1'b0;
            end
            i2cbs_pkg::CMD_WRITE: begin
                case (phase)
                    3'd0: begin
                        scl_q = 1'b0;
                        sda_q = ((shreg & i2cbs_pkg::BYTE_MSB) != 8'd0);
                    end
                    3'd1: scl_q = 1'b1;
                    3'd2: scl_q = 1'b0;
                    3'd3: begin
                        scl_q = 1'b0;
                        sda_q = 1'b1;
                    end
                    default: scl_q = 1'b1;
                endcase
            end
            i2cbs_pkg::CMD_READ: begin
                if (phase == 3'd0) begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                end
            end
            i2cbs_pkg::CMD_STOP: begin
                if (phase == 3'd0) scl_q = 1'b0;
                else if (phase == 3'd1) sda_q = 1'b0;
                else if (phase == 3'd2) scl_q = 1'b1;
                else sda_q = 1'b1;
            end
            i2cbs_pkg::CMD_ACK: scl_q = 1'b1;
            default: ;
        endcase
    endfunction

    function void go_idle();
        run_cmd = i2cbs_pkg::CMD_IDLE;
        phase   = 3'd0;
        bit_cnt = 4'd0;
    endfunction

    // Moves the running command past the end of a phase; true when a read byte is done.
    function bit close_phase(input logic sda_bit);
        bit read_done;
        read_done = 1'b0;
        case (run_cmd)
            i2cbs_pkg::CMD_START: begin
                if (phase < 3'd3) begin
                    phase = phase + 3'd1;
                end else begin
                    // The address byte goes out exactly like a write.
                    run_cmd = i2cbs_pkg::CMD_WRITE;
                    phase   = 3'd0;
                    bit_cnt = 4'd0;
                end
            end
            i2cbs_pkg::CMD_WRITE: begin
                if (phase == 3'd2) begin
                    shreg   = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    phase   = (bit_cnt < i2cbs_pkg::BITS_PER_BYTE) ? 3'd0 : 3'd3;
                end else if (phase < 3'd4) begin
                    phase = phase + 3'd1;
                end else begin
                    scl_q = 1'b0;
                    go_idle();
                end
            end
            i2cbs_pkg::CMD_READ: begin
                if (phase == 3'd0) begin
                    shreg = {shreg[6:0], sda_bit};
                    phase = 3'd1;
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < i2cbs_pkg::BITS_PER_BYTE) begin
                        phase = 3'd0;
                    end else begin
                        scl_q     = 1'b0;
                        read_done = 1'b1;
                        go_idle();
                    end
                end
            end
            i2cbs_pkg::CMD_STOP: begin
                if (phase < 3'd3) phase = phase + 3'd1;
                else go_idle();
            end
            default: begin
                scl_q = 1'b0;
                go_idle();
            end
        endcase
        if (run_cmd != i2cbs_pkg::CMD_IDLE) apply_levels();
        return read_done;
    endfunction

    // Advances the model by one bus tick and returns the result it should produce.
    function i2cbs_pkg::i2cbs_out_t next_lines(input i2cbs_pkg::i2cbs_in_t req);
        i2cbs_pkg::i2cbs_out_t res;
        logic [15:0]           hp;
        bit                    done;
        hp   = (half_per == 16'd0) ? 16'd1 : half_per;
        done = 1'b0;
        // A command only starts from idle; anything else is a plain tick.
        if (run_cmd == i2cbs_pkg::CMD_IDLE && req.op >= i2cbs_pkg::CMD_START &&
            req.op <= i2cbs_pkg::CMD_ACK) begin
            run_cmd  = i2cbs_pkg::cmd_t'(req.op);
            phase    = 3'd0;
            bit_cnt  = 4'd0;
            tick_cnt = 16'd0;
            case (run_cmd)
                i2cbs_pkg::CMD_START:
                    shreg = req.read_dir ? (req.data | i2cbs_pkg::READ_BIT) : req.data;
                i2cbs_pkg::CMD_WRITE: shreg = req.data;
                i2cbs_pkg::CMD_READ:  shreg = 8'd0;
                i2cbs_pkg::CMD_ACK:   sda_q = ~req.ack_enable;
                default: ;
            endcase
            apply_levels();
        end
        res.scl = scl_q;
        res.sda = sda_q;
        if (run_cmd != i2cbs_pkg::CMD_IDLE) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= hp) begin
                tick_cnt = 16'd0;
                done     = close_phase(req.sda_in);
            end
        end
        res.busy_res   = (run_cmd != i2cbs_pkg::CMD_IDLE);
        res.read_valid = done;
        res.read_data  = done ? shreg : 8'd0;
        return res;
    endfunction

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Track configuration, predict on each request, compare on each result.
    always @(posedge aclk) begin
        i2cbs_pkg::i2cbs_out_t want;
        if (!aresetn) begin
            run_cmd  = i2cbs_pkg::CMD_IDLE;
            phase    = 3'd0;
            bit_cnt  = 4'd0;
            shreg    = 8'd0;
            tick_cnt = 16'd0;
            scl_q    = 1'b0;
            sda_q    = 1'b1;
            half_per = i2cbs_pkg::HALF_PERIOD_RESET;
            expected_lines.delete();
        end else begin
            if (cfg_we) half_per = cfg_wdata;
            if (s_valid && s_ready) expected_lines.push_back(next_lines(s_data));
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no request pending, expected none, actual %0h",
                             $time, m_data);
                end else begin
                    want = expected_lines.pop_front();
                    check_field("scl", {7'd0, want.scl}, {7'd0, m_data.scl});
                    check_field("sda", {7'd0, want.sda}, {7'd0, m_data.sda});
                    check_field("busy_res", {7'd0, want.busy_res}, {7'd0, m_data.busy_res});
                    check_field("read_valid", {7'd0, want.read_valid},
                                {7'd0, m_data.read_valid});
                    check_field("read_data", want.read_data, m_data.read_data);
                end
            end
        end
        pending_count = unsigned'(expected_lines.size());
    end

endmodule

/* sim/i2c_master_bit_sequencer_top_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C bit sequencer testbench
// Drives bus tick requests into the sequencer: directed commands first, then
// random transactions at several half periods, with random idling on both
// channels and one long result stall. The checker beside the block predicts and
// compares every result; this module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer_top_test;

    // Op codes outside the command enum: a plain tick and the two unused codes.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    localparam int unsigned ITEMS_PER_SETTING = 110;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    i2cbs_pkg::i2cbs_in_t  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    i2cbs_pkg::i2cbs_out_t m_data;
    logic                  cfg_we    = 1'b0;
    logic [15:0]           cfg_wdata = 16'd0;

    int unsigned fail_count;
    int unsigned pending_count;

    // Stimulus side bookkeeping.
    logic [15:0] bus_half_period = i2cbs_pkg::HALF_PERIOD_RESET;
    bit          pacing_on       = 1'b1;
    int unsigned hold_off_cycles = 0;
    int unsigned items_sent      = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    i2c_master_bit_sequencer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2c_master_bit_sequencer_checker u_check (.*);

    // Offers one request, with an occasional idle burst first, and waits for it to be taken.
    task automatic send_item(input i2cbs_pkg::i2cbs_in_t req);
        if (pacing_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Number of half periods a command keeps the sequencer busy.
    function automatic int unsigned phase_count(input logic [2:0] op);
        case (op)
            i2cbs_pkg::CMD_START: return 30;
            i2cbs_pkg::CMD_WRITE: return 26;
            i2cbs_pkg::CMD_READ:  return 16;
            i2cbs_pkg::CMD_STOP:  return 4;
            i2cbs_pkg::CMD_ACK:   return 1;
            default:              return 0;
        endcase
    endfunction

    // Sends a command request followed by enough tick requests to see it through.
    // During a read, sda_in carries bus_bits MSB first; noise_pct is the chance that
    // a tick request carries a random op, which the busy sequencer must ignore.
    task automatic run_command(input logic [2:0] op, input logic [7:0] byte_val,
                               input logic dir, input logic ack_en,
                               input logic [7:0] bus_bits, input int unsigned noise_pct);
        int unsigned          hp;
        int unsigned          ticks;
        int unsigned          phase_no;
        i2cbs_pkg::i2cbs_in_t req;
        hp    = (bus_half_period == 16'd0) ? 1 : 32'(bus_half_period);
        ticks = (phase_count(op) == 0) ? 1 : phase_count(op) * hp;
        for (int unsigned k = 0; k < ticks; k++) begin
            req.op         = OP_TICK;
            req.data       = 8'($urandom);
            req.read_dir   = 1'($urandom);
            req.ack_enable = 1'($urandom);
            req.sda_in     = 1'($urandom);
            if ($urandom_range(1, 100) <= noise_pct)
                req.op = 3'($urandom_range(OP_TICK, OP_BAD_HI));
            if (k == 0) begin
                req.op         = op;
                req.data       = byte_val;
                req.read_dir   = dir;
                req.ack_enable = ack_en;
            end
            if (op == i2cbs_pkg::CMD_READ) begin
                phase_no   = k / hp;
                req.sda_in = bus_bits[7 - phase_no / 2];
            end
            send_item(req);
        end
    endtask

    // Writes the half period once every predicted result has come back.
    task automatic set_half_period(input logic [15:0] value);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        cfg_we          <= 1'b1;
        cfg_wdata       <= value;
        bus_half_period = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly a well-formed start, data bytes and stop; otherwise a lone random request.
    task automatic random_transaction(input int unsigned noise_pct);
        int unsigned n;
        logic        rd;
        if ($urandom_range(0, 9) < 7) begin
            rd = 1'($urandom);
            run_command(i2cbs_pkg::CMD_START, 8'($urandom), rd, 1'($urandom), 8'($urandom),
                        noise_pct);
            n = $urandom_range(1, 3);
            for (int unsigned i = 0; i < n; i++) begin
                if (rd) begin
                    run_command(i2cbs_pkg::CMD_READ, 8'($urandom), 1'($urandom),
                                1'($urandom), 8'($urandom), noise_pct);
                    // Acknowledge all but the last byte.
                    run_command(i2cbs_pkg::CMD_ACK, 8'($urandom), 1'($urandom),
                                (i + 1 < n), 8'($urandom), noise_pct);
                end else begin
                    run_command(i2cbs_pkg::CMD_WRITE, 8'($urandom), 1'($urandom),
                                1'($urandom), 8'($urandom), noise_pct);
                end
            end
            // Now and then the stop is left out, so the next start begins mid-transfer.
            if ($urandom_range(0, 7) != 0)
                run_command(i2cbs_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom),
                            8'($urandom), noise_pct);
        end else begin
            run_command(3'($urandom_range(OP_TICK, OP_BAD_HI)), 8'($urandom), 1'($urandom),
                        1'($urandom), 8'($urandom), noise_pct);
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin : result_sink
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_cycles != 0) begin
                m_ready         <= 1'b0;
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
                repeat (stall) @(negedge aclk);
            end else if (pacing_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [15:0]          settings [5];
        int unsigned          base;
        i2cbs_pkg::i2cbs_in_t req;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset lines on an idle tick, then a send-ack at the reset half period.
        run_command(OP_TICK, 8'hFF, 1'b1, 1'b1, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_ACK, 8'h00, 1'b0, 1'b1, 8'h00, 0);

        set_half_period(16'd1);
        // Unknown ops act as plain ticks.
        run_command(OP_BAD_LO, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        run_command(OP_BAD_HI, 8'hFF, 1'b1, 1'b1, 8'h00, 0);
        // Start with SDA held low by the previous acknowledge.
        run_command(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0, 8'h00, 0);
        // Every tick of this write carries a random op that must be ignored.
        run_command(i2cbs_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b1, 8'h00, 100);
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        // Start after stop, with the read bit already set and then forced.
        run_command(i2cbs_pkg::CMD_START, 8'hFF, 1'b1, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_START, 8'hA4, 1'b1, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 8'hFF, 0);
        run_command(i2cbs_pkg::CMD_ACK, 8'h00, 1'b0, 1'b1, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_READ, 8'hFF, 1'b1, 1'b1, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_ACK, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 8'h5A, 0);
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 0);
        run_command(OP_TICK, 8'h00, 1'b0, 1'b0, 8'h00, 0);

        set_half_period(16'd2);
        run_command(i2cbs_pkg::CMD_START, 8'h3C, 1'b0, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, 8'h00, 0);
        run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 8'hC3, 0);
        run_command(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 0);

        // Random transactions over a few half periods; the third one gets a long stall.
        settings = '{16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 5)), 16'd1};
        foreach (settings[i]) begin
            set_half_period(settings[i]);
            if (i == 2) hold_off_cycles = 60;
            base = items_sent;
            while (items_sent < base + ITEMS_PER_SETTING) random_transaction(10);
        end

        // Last part without idling: zero half period, then the largest one.
        pacing_on = 1'b0;
        set_half_period(16'd0);
        base = items_sent;
        while (items_sent < base + 60) random_transaction(10);
        set_half_period(16'hFFFF);
        // Only the opening ticks of a send-ack at the longest phase.
        req            = '0;
        req.op         = i2cbs_pkg::CMD_ACK;
        req.ack_enable = 1'b1;
        send_item(req);
        req.op = OP_TICK;
        repeat (8) send_item(req);

        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
